FILE: design/chs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chs_pkg;

    localparam int MAX_ENTRIES = 128;
    localparam int IDX_W       = 7;
    localparam int LEN_W       = 8;
    localparam int LFSR_W      = 32;
    localparam int MOD_BITS    = 4;
    localparam int MOD_STEPS   = LFSR_W / MOD_BITS;
    localparam int MCNT_W      = $clog2(MOD_STEPS);

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'hD000_0001;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_LOAD    = 2'd0;
    localparam cmd_t CMD_TICK    = 2'd1;
    localparam cmd_t CMD_RESTART = 2'd2;

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_LENGTH = 2'd0;
    localparam cfg_idx_t CFG_RANDOM = 2'd1;
    localparam cfg_idx_t CFG_SEED   = 2'd2;

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        lfsr_step = (v >> 1) ^ (v[0] ? LFSR_TAPS : '0);
    endfunction

endpackage

`default_nettype wire

FILE: design/channel_hop_sequencer.sv
// Load/restart complete in S_IDLE. A sequential tick goes through S_CHRD to S_OUT; a random
// tick goes through S_ORD, S_CHRD and S_OUT, after a reshuffle when one is due: S_FILL writes len
// entries, then each swap takes a draw, MOD_STEPS modulo steps, a read and two writes.
// Ready again right after the result registers; a full output slot holds the block in S_OUT.
// rst_n (async, active low) clears control state; length 1, sequential mode, LFSR = 1.
// Channel and order tables are not cleared by reset.
`timescale 1ns / 1ps
`default_nettype none

module channel_hop_sequencer
    import chs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // entry_index[6:0], entry_channel[13:7]
    input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // channel[6:0], position[13:7]
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FILL = 4'd1;
    localparam logic [3:0] S_DRAW = 4'd2;
    localparam logic [3:0] S_MOD  = 4'd3;
    localparam logic [3:0] S_SWRD = 4'd4;
    localparam logic [3:0] S_SWW1 = 4'd5;
    localparam logic [3:0] S_SWW2 = 4'd6;
    localparam logic [3:0] S_ORD  = 4'd7;
    localparam logic [3:0] S_CHRD = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic [LFSR_W-1:0] div_reg, div_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [MCNT_W-1:0] mcnt_reg, mcnt_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              rnd_reg, rnd_next;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_chan_reg, out_chan_next;
    logic [IDX_W-1:0]  out_pos_reg, out_pos_next;

    logic [IDX_W-1:0] chan_mem [MAX_ENTRIES];
    logic [IDX_W-1:0] order_mem [MAX_ENTRIES];
    logic [IDX_W-1:0] chan_rd_reg;
    logic [IDX_W-1:0] ord_rd_a_reg, ord_rd_b_reg;

    logic             chan_we, chan_re, ord_we, ord_re;
    logic [IDX_W-1:0] chan_wa, chan_wd, chan_ra;
    logic [IDX_W-1:0] ord_wa, ord_wd, ord_ra;

    logic             in_acc;
    cmd_t             in_cmd;
    logic [IDX_W-1:0] in_idx, in_chan;
    logic [LEN_W-1:0] eff_len, pos_inc, divisor, rem_calc;
    logic [LEN_W:0]   mod_t;
    logic             wrap;

    assign in_cmd  = s_axis_tuser;
    assign in_idx  = s_axis_tdata[IDX_W-1:0];
    assign in_chan = s_axis_tdata[2*IDX_W-1:IDX_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_pos_reg, out_chan_reg};

    always_comb
    begin
        if (len_reg == '0)
            eff_len = LEN_W'(1);
        else if (len_reg > LEN_W'(MAX_ENTRIES))
            eff_len = LEN_W'(MAX_ENTRIES);
        else
            eff_len = len_reg;
    end

    assign pos_inc = {1'b0, pos_reg} + LEN_W'(1);
    assign wrap    = (pos_inc >= eff_len);
    assign divisor = {1'b0, i_reg} + LEN_W'(1);

    // Restoring remainder, MOD_BITS dividend bits per cycle
    always_comb
    begin
        rem_calc = rem_reg;
        mod_t    = '0;
        for (int k = 0; k < MOD_BITS; k++)
        begin
            mod_t = {rem_calc, div_reg[LFSR_W-1-k]};
            if (mod_t >= {1'b0, divisor})
                mod_t = mod_t - {1'b0, divisor};
            rem_calc = mod_t[LEN_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        pend_next      = pend_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        lfsr_next      = lfsr_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        mcnt_next      = mcnt_reg;
        len_next       = len_reg;
        rnd_next       = rnd_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_chan_next  = out_chan_reg;
        out_pos_next   = out_pos_reg;
        chan_we        = 1'b0;
        chan_wa        = in_idx;
        chan_wd        = in_chan;
        chan_re        = 1'b0;
        chan_ra        = rnd_reg ? ord_rd_a_reg : pos_reg;
        ord_we         = 1'b0;
        ord_wa         = i_reg;
        ord_wd         = i_reg;
        ord_re         = 1'b0;
        ord_ra         = i_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_cmd)
                        CMD_LOAD:
                        begin
                            chan_we = ({1'b0, in_idx} < LEN_W'(MAX_ENTRIES));
                        end
                        CMD_RESTART:
                        begin
                            pos_next  = '0;
                            pend_next = 1'b1;
                        end
                        CMD_TICK:
                        begin
                            pos_next = wrap ? '0 : pos_inc[IDX_W-1:0];
                            if (rnd_reg)
                            begin
                                pend_next = 1'b0;
                                i_next    = '0;
                                if (pend_reg || wrap)
                                    state_next = S_FILL;
                                else
                                    state_next = S_ORD;
                            end
                            else
                            begin
                                pend_next  = pend_reg || wrap;
                                state_next = S_CHRD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                ord_we = 1'b1;
                if (divisor == eff_len)
                begin
                    if (i_reg == '0)
                        state_next = S_ORD;
                    else
                        state_next = S_DRAW;
                end
                else
                begin
                    i_next = i_reg + IDX_W'(1);
                end
            end
            S_DRAW:
            begin
                lfsr_next  = lfsr_step(lfsr_reg);
                div_next   = lfsr_step(lfsr_reg);
                rem_next   = '0;
                mcnt_next  = '0;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                rem_next  = rem_calc;
                div_next  = div_reg << MOD_BITS;
                mcnt_next = mcnt_reg + MCNT_W'(1);
                if (mcnt_reg == MCNT_W'(MOD_STEPS - 1))
                begin
                    j_next     = rem_calc[IDX_W-1:0];
                    state_next = S_SWRD;
                end
            end
            S_SWRD:
            begin
                ord_re     = 1'b1;
                state_next = S_SWW1;
            end
            S_SWW1:
            begin
                ord_we     = 1'b1;
                ord_wd     = ord_rd_b_reg;
                state_next = S_SWW2;
            end
            S_SWW2:
            begin
                ord_we = 1'b1;
                ord_wa = j_reg;
                ord_wd = ord_rd_a_reg;
                if (i_reg == IDX_W'(1))
                    state_next = S_ORD;
                else
                begin
                    i_next     = i_reg - IDX_W'(1);
                    state_next = S_DRAW;
                end
            end
            S_ORD:
            begin
                ord_re     = 1'b1;
                ord_ra     = pos_reg;
                state_next = S_CHRD;
            end
            S_CHRD:
            begin
                chan_re    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_chan_next  = chan_rd_reg;
                    out_pos_next   = pos_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_LENGTH:
                begin
                    len_next  = cfg_data[LEN_W-1:0];
                    pos_next  = '0;
                    pend_next = 1'b1;
                end
                CFG_RANDOM:
                begin
                    rnd_next  = cfg_data[0];
                    pos_next  = '0;
                    pend_next = 1'b1;
                end
                CFG_SEED:
                begin
                    lfsr_next = (cfg_data == '0) ? LFSR_W'(1) : cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            pend_reg      <= 1'b1;
            i_reg         <= '0;
            j_reg         <= '0;
            lfsr_reg      <= LFSR_W'(1);
            mcnt_reg      <= '0;
            len_reg       <= LEN_W'(1);
            rnd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            pend_reg      <= pend_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            lfsr_reg      <= lfsr_next;
            mcnt_reg      <= mcnt_next;
            len_reg       <= len_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        out_chan_reg <= out_chan_next;
        out_pos_reg  <= out_pos_next;
    end

    always_ff @(posedge clk)
    begin
        if (chan_we)
            chan_mem[chan_wa] <= chan_wd;
        if (chan_re)
            chan_rd_reg <= chan_mem[chan_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
            order_mem[ord_wa] <= ord_wd;
        if (ord_re)
        begin
            ord_rd_a_reg <= order_mem[ord_ra];
            ord_rd_b_reg <= order_mem[j_reg];
        end
    end

    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("LFSR reached the all-zero lockup value");

    a_draw_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAW) |-> (i_reg != '0))
        else $error("shuffle draw with index zero");

    a_swap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWRD) |-> (j_reg <= i_reg))
        else $error("swap partner beyond current index");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !m_axis_tready) |=> (state_reg == S_OUT))
        else $error("result left pending state while output slot busy");

endmodule

`default_nettype wire

FILE: tb/sv/channel_hop_sequencer_tb.sv
`timescale 1ns / 1ps

module channel_hop_sequencer_tb;

    import chs_pkg::*;

    localparam cmd_t CMD_UNUSED  = 2'd3;
    localparam int   LONG_HOLD   = 400;
    localparam int   SETTLE_CYC  = 20;
    localparam int   CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        bit [6:0] channel;
        bit [6:0] position;
    } hop_t;

    class hop_channel_tracker;
        bit [6:0]  chan_table [MAX_ENTRIES];
        bit [6:0]  order_table [MAX_ENTRIES];
        bit [6:0]  hop_pos;
        bit        reshuffle_due;
        bit [31:0] lfsr;
        bit [7:0]  length_reg;
        bit        random_mode;
        hop_t      pending_hops [$];
        int        errors;
        int        hops_seen;
        int        loads;
        int        restarts;
        int        shuffles;

        function new();
            hop_pos       = '0;
            reshuffle_due = 1'b1;
            lfsr          = 32'd1;
            length_reg    = 8'd1;
            random_mode   = 1'b0;
        endfunction

        function void write_register(cfg_idx_t idx, bit [31:0] value);
            case (idx)
                CFG_LENGTH:
                begin
                    length_reg    = value[7:0];
                    hop_pos       = '0;
                    reshuffle_due = 1'b1;
                end
                CFG_RANDOM:
                begin
                    random_mode   = value[0];
                    hop_pos       = '0;
                    reshuffle_due = 1'b1;
                end
                CFG_SEED:
                    lfsr = (value == 32'd0) ? 32'd1 : value;
                default: ;
            endcase
        endfunction

        function void reshuffle(int len);
            bit [31:0] span;
            int        j;
            bit [6:0]  t;
            for (int i = 0; i < len; i++)
                order_table[i] = 7'(i);
            for (int i = len - 1; i > 0; i--)
            begin
                lfsr           = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : 32'd0);
                span           = 32'(i + 1);
                j              = int'(lfsr % span);
                t              = order_table[i];
                order_table[i] = order_table[j];
                order_table[j] = t;
            end
            shuffles++;
        endfunction

        function void note_command(cmd_t op, bit [6:0] index, bit [6:0] chan);
            int   len;
            int   next_pos;
            int   sel;
            hop_t want;
            case (op)
                CMD_LOAD:
                begin
                    chan_table[index] = chan;
                    loads++;
                end
                CMD_RESTART:
                begin
                    hop_pos       = '0;
                    reshuffle_due = 1'b1;
                    restarts++;
                end
                CMD_TICK:
                begin
                    if (length_reg == 8'd0)
                        len = 1;
                    else if (length_reg > MAX_ENTRIES)
                        len = MAX_ENTRIES;
                    else
                        len = length_reg;
                    next_pos = hop_pos + 1;
                    if (next_pos >= len)
                    begin
                        next_pos      = 0;
                        reshuffle_due = 1'b1;
                    end
                    hop_pos = 7'(next_pos);
                    if (random_mode)
                    begin
                        if (reshuffle_due)
                        begin
                            reshuffle(len);
                            reshuffle_due = 1'b0;
                        end
                        sel = order_table[hop_pos];
                    end
                    else
                        sel = hop_pos;
                    want.channel  = chan_table[sel];
                    want.position = hop_pos;
                    pending_hops.push_back(want);
                end
                default: ;
            endcase
        endfunction

        function void check_hop(logic [6:0] channel, logic [6:0] position);
            hop_t want;
            hops_seen++;
            if (pending_hops.size() == 0)
            begin
                $error("hop result with nothing pending: channel %0d position %0d",
                       channel, position);
                errors++;
                return;
            end
            want = pending_hops.pop_front();
            if (channel !== want.channel)
            begin
                $error("channel: expected %0d, actual %0d", want.channel, channel);
                errors++;
            end
            if (position !== want.position)
            begin
                $error("position: expected %0d, actual %0d", want.position, position);
                errors++;
            end
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // entry_index[6:0], entry_channel[13:7]
    logic [1:0]  s_axis_tuser  = '0;   // cmd[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // channel[6:0], position[13:7]
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_index     = '0;
    logic [31:0] cfg_data      = '0;

    hop_channel_tracker board;
    bit tx_fast       = 1'b0;
    bit rx_fast       = 1'b0;
    bit long_hold_req = 1'b0;
    int settings_used = 0;
    int cycles        = 0;

    channel_hop_sequencer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("channel_hop_sequencer regression: fail");
            $finish;
        end
    end

    task automatic issue_command(input cmd_t op, input bit [6:0] index, input bit [6:0] chan);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, chan, index};
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        board.note_command(op, index, chan);
        @(negedge clk);
    endtask

    // wait out every pending hop, then let loads and restarts retire
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.pending_hops.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic set_register(input cfg_idx_t idx, input bit [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        board.write_register(idx, value);
        @(negedge clk);
    endtask

    task automatic apply_setting(input bit [7:0] len, input bit rnd, input bit [31:0] seed);
        settle();
        set_register(CFG_LENGTH, {24'd0, len});
        set_register(CFG_RANDOM, {31'd0, rnd});
        set_register(CFG_SEED, seed);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic hop_traffic(input int item_total);
        int issued;
        int roll;
        issued = 0;
        while (issued < item_total)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 78)
                issue_command(CMD_TICK, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            else if (roll < 90)
                issue_command(CMD_LOAD, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            else if (roll < 95)
                issue_command(CMD_RESTART, 7'($urandom_range(0, 127)),
                              7'($urandom_range(0, 127)));
            else
                issue_command(CMD_UNUSED, 7'($urandom_range(0, 127)),
                              7'($urandom_range(0, 127)));
            if (roll < 95)
                issued++;
        end
    endtask

    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                stall         = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else
                stall = rx_fast ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            board.check_hop(m_axis_tdata[6:0], m_axis_tdata[13:7]);
        end
    end

    initial
    begin : stimulus
        bit [7:0]  len;
        bit        rnd;
        bit [31:0] seed;
        int        item_total;
        board = new();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // whole table written up front so no tick reads an unloaded entry
        for (int i = 0; i < MAX_ENTRIES; i++)
            issue_command(CMD_LOAD, 7'(i), 7'($urandom_range(0, 127)));

        // reset settings: length one, sequential
        issue_command(CMD_LOAD, 7'd0, 7'd127);
        issue_command(CMD_LOAD, 7'd127, 7'd0);
        issue_command(CMD_TICK, 7'd0, 7'd0);
        issue_command(CMD_TICK, 7'd127, 7'd127);
        issue_command(CMD_UNUSED, 7'd127, 7'd127);
        issue_command(CMD_RESTART, 7'd0, 7'd0);
        issue_command(CMD_TICK, 7'd0, 7'd0);

        // zero length acts as one, zero seed loads one
        apply_setting(8'd0, 1'b1, 32'd0);
        issue_command(CMD_TICK, 7'd0, 7'd0);
        issue_command(CMD_TICK, 7'd0, 7'd0);

        // oversized length saturates
        apply_setting(8'd255, 1'b1, 32'hFFFF_FFFF);
        issue_command(CMD_TICK, 7'd0, 7'd0);
        issue_command(CMD_TICK, 7'd0, 7'd0);
        issue_command(CMD_RESTART, 7'd0, 7'd0);
        issue_command(CMD_TICK, 7'd0, 7'd0);

        apply_setting(8'd3, 1'b1, 32'd5);
        repeat (7) issue_command(CMD_TICK, 7'd0, 7'd0);
        issue_command(CMD_LOAD, 7'd2, 7'h55);
        repeat (3) issue_command(CMD_TICK, 7'd0, 7'd0);
        issue_command(CMD_RESTART, 7'd0, 7'd0);
        issue_command(CMD_TICK, 7'd0, 7'd0);

        for (int p = 0; p < 10; p++)
        begin
            tx_fast    = (p == 2) || (p == 8);
            rx_fast    = (p == 4) || (p == 8);
            item_total = 90;
            seed       = $urandom();
            len        = 8'($urandom_range(2, 16));
            rnd        = 1'b1;
            case (p)
                0:
                begin
                    len        = 8'd128;
                    rnd        = 1'b0;
                    item_total = 180;
                end
                1: len = 8'd1;
                3:
                begin
                    len        = 8'd128;
                    seed       = 32'hFFFF_FFFF;
                    item_total = 160;
                end
                4: rnd = 1'b0;
                5:
                begin
                    len        = 8'd200;
                    item_total = 80;
                end
                6: len = 8'd2;
                7, 8, 9:
                begin
                    len = 8'($urandom_range(1, 32));
                    rnd = 1'($urandom_range(0, 1));
                end
                default: ;
            endcase
            apply_setting(len, rnd, seed);
            if (p == 2)
                long_hold_req = 1'b1;
            hop_traffic(item_total);
        end
        settle();

        $display("covered %0d hop results, %0d table loads, %0d restarts, %0d reshuffles",
                 board.hops_seen, board.loads, board.restarts, board.shuffles);
        $display("across %0d register settings incl. zero/oversized length and zero seed",
                 settings_used);
        if (board.errors == 0)
            $display("channel_hop_sequencer regression: pass");
        else
            $display("channel_hop_sequencer regression: fail");
        $finish;
    end

endmodule
